>>> design/air_quality_index_daily_summary_assert.svh
// Assertion macros for the air quality index daily summary block.
`ifndef AIR_QUALITY_INDEX_DAILY_SUMMARY_ASSERT_SVH
`define AIR_QUALITY_INDEX_DAILY_SUMMARY_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define AQIDS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define AQIDS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/aqids_pkg.sv
// Shared types, constants and functions of the air quality index daily summary block.
package aqids_pkg;

  // PM2.5 breakpoint segments
  typedef enum logic [2:0] {
    SEG_GOOD,
    SEG_MODERATE,
    SEG_SENSITIVE,
    SEG_UNHEALTHY,
    SEG_VERY_UNHEALTHY,
    SEG_HAZARDOUS
  } aqi_seg_t;

  localparam int SEG_N = 6;

  localparam logic [13:0] AQI_CLO [SEG_N] = '{
    14'd0, 14'd121, 14'd355, 14'd555, 14'd1505, 14'd2505
  };
  localparam logic [7:0] AQI_K [SEG_N] = '{
    8'd50, 8'd49, 8'd49, 8'd49, 8'd99, 8'd199
  };
  localparam logic [8:0] AQI_ILO [SEG_N] = '{
    9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301
  };
  // floor(n / (chi - clo)) as (n * M) >> SH, exact over each segment's numerator range
  localparam logic [4:0] AQI_SH [SEG_N] = '{
    5'd20, 5'd22, 5'd22, 5'd26, 5'd27, 5'd31
  };
  localparam logic [19:0] AQI_M [SEG_N] = '{
    20'(((64'd1 << 20) + 64'd119) / 64'd120),
    20'(((64'd1 << 22) + 64'd232) / 64'd233),
    20'(((64'd1 << 22) + 64'd198) / 64'd199),
    20'(((64'd1 << 26) + 64'd948) / 64'd949),
    20'(((64'd1 << 27) + 64'd998) / 64'd999),
    20'(((64'd1 << 31) + 64'd2494) / 64'd2495)
  };
  // top segment offset above this always saturates
  localparam logic [11:0] AQI_X_MAX = 12'd2600;
  localparam logic [8:0]  AQI_MAX   = 9'd500;

  localparam int AQI_NUM_W = 19;
  localparam int THI_NUM_W = 19;

  // THI: floor((800*T + H*(T-144) + 464000) / 1000), clamped
  localparam logic signed [11:0] THI_T_OFS  = 12'sd144;
  localparam logic signed [21:0] THI_T_GAIN = 22'sd800;
  localparam logic signed [23:0] THI_BIAS   = 24'sd464000;
  localparam logic signed [23:0] THI_X_MIN  = -24'sd400000;
  localparam logic signed [23:0] THI_X_MAX  = 24'sd1850999;
  localparam logic signed [23:0] THI_X_OFS  = 24'sd400000;
  localparam int                 THI_SH     = 26;
  localparam logic [19:0]        THI_M      = 20'(((64'd1 << 26) + 64'd124) / 64'd125);
  localparam logic [11:0]        THI_Q_OFS  = 12'd400;
  localparam logic signed [11:0] THI_MIN    = -12'sd400;
  localparam logic signed [11:0] THI_MAX    = 12'sd1850;
  localparam logic signed [11:0] THI_LIM_1  = 12'sd270;
  localparam logic signed [11:0] THI_LIM_2  = 12'sd290;
  localparam logic signed [11:0] THI_LIM_3  = 12'sd320;
  localparam logic signed [11:0] THI_LIM_4  = 12'sd350;

  // category limits and codes
  localparam logic [8:0] AQI_LIM_GOOD      = 9'd50;
  localparam logic [8:0] AQI_LIM_MODERATE  = 9'd100;
  localparam logic [8:0] AQI_LIM_SENSITIVE = 9'd150;
  localparam logic [8:0] AQI_LIM_UNHEALTHY = 9'd200;

  localparam logic [2:0] AQI_LVL_GOOD           = 3'd0;
  localparam logic [2:0] AQI_LVL_MODERATE       = 3'd1;
  localparam logic [2:0] AQI_LVL_SENSITIVE      = 3'd2;
  localparam logic [2:0] AQI_LVL_UNHEALTHY      = 3'd3;
  localparam logic [2:0] AQI_LVL_VERY_UNHEALTHY = 3'd4;

  localparam logic [1:0] CO2_LVL_GOOD     = 2'd0;
  localparam logic [1:0] CO2_LVL_MODERATE = 2'd1;
  localparam logic [1:0] CO2_LVL_POOR     = 2'd2;
  localparam logic [1:0] CO2_LVL_SEVERE   = 2'd3;

  localparam logic [1:0] THI_LVL_0 = 2'd0;
  localparam logic [1:0] THI_LVL_1 = 2'd1;
  localparam logic [1:0] THI_LVL_2 = 2'd2;
  localparam logic [1:0] THI_LVL_3 = 2'd3;

  localparam logic [2:0] REC_THI_LVL_0 = 3'd0;
  localparam logic [2:0] REC_THI_LVL_1 = 3'd1;
  localparam logic [2:0] REC_THI_LVL_2 = 3'd2;
  localparam logic [2:0] REC_THI_LVL_3 = 3'd3;
  localparam logic [2:0] REC_THI_LVL_4 = 3'd4;

  // configuration register map
  localparam int         CFG_IDX_W        = 2;
  localparam logic [1:0] CFG_CO2_GOOD     = 2'd0;
  localparam logic [1:0] CFG_CO2_MODERATE = 2'd1;
  localparam logic [1:0] CFG_CO2_HIGH     = 2'd2;

  localparam logic [13:0] CO2_GOOD_RST     = 14'd800;
  localparam logic [13:0] CO2_MODERATE_RST = 14'd1200;
  localparam logic [13:0] CO2_HIGH_RST     = 14'd2000;

  localparam int FIFO_DEPTH = 2;

  typedef struct packed {
    logic [13:0] co2_good;
    logic [13:0] co2_moderate;
    logic [13:0] co2_high;
  } cfg_t;

  typedef struct packed {
    aqi_seg_t               seg;
    logic [AQI_NUM_W-1:0]   aqi_num;
    logic [THI_NUM_W-1:0]   thi_num;
    logic [13:0]            co2;
    logic [1:0]             co2_lvl;
  } item_t;

  typedef struct packed {
    logic [8:0]         aqi_index;
    logic [2:0]         aqi_level;
    logic [1:0]         co2_level;
    logic signed [11:0] thi_tenths;
    logic [1:0]         thi_level;
    logic               day_done;
    logic [8:0]         avg_aqi;
    logic [13:0]        avg_co2;
    logic signed [11:0] avg_thi_tenths;
    logic [2:0]         rec_aqi_level;
    logic [1:0]         rec_co2_level;
    logic [2:0]         rec_thi_level;
  } result_t;

  function automatic logic [2:0] aqi_category(input logic [8:0] a);
    logic [2:0] lvl;
    if (a <= AQI_LIM_GOOD) lvl = AQI_LVL_GOOD;
    else if (a <= AQI_LIM_MODERATE) lvl = AQI_LVL_MODERATE;
    else if (a <= AQI_LIM_SENSITIVE) lvl = AQI_LVL_SENSITIVE;
    else if (a <= AQI_LIM_UNHEALTHY) lvl = AQI_LVL_UNHEALTHY;
    else lvl = AQI_LVL_VERY_UNHEALTHY;
    return lvl;
  endfunction

endpackage

>>> design/aqids_front.sv
// Front end: accepts samples, picks the PM2.5 segment and forms the AQI and THI numerators.
module aqids_front (
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [13:0]               in_pm25_tenths,
  input  logic [13:0]               in_co2_ppm,
  input  logic signed [10:0]        in_temperature_tenths,
  input  logic [9:0]                in_humidity_tenths,
  input  aqids_pkg::cfg_t           cfg,
  input  logic                      fifo_full,
  output logic                      fifo_push,
  output aqids_pkg::item_t          fifo_wdata
);

  aqids_pkg::aqi_seg_t seg;
  logic [13:0]         pm_off;
  logic [11:0]         pm_x;
  logic [19:0]         aqi_prod;
  logic signed [11:0]  t_off;
  logic signed [10:0]  h_s;
  logic signed [22:0]  h_prod;
  logic signed [21:0]  t_gain;
  logic signed [23:0]  thi_x;
  logic signed [23:0]  thi_c;
  logic signed [23:0]  thi_y;
  logic [1:0]          co2_lvl;

  assign in_ready  = !fifo_full;
  assign fifo_push = in_valid && !fifo_full;

  always_comb begin
    if (in_pm25_tenths < aqids_pkg::AQI_CLO[aqids_pkg::SEG_MODERATE]) begin
      seg = aqids_pkg::SEG_GOOD;
    end else if (in_pm25_tenths < aqids_pkg::AQI_CLO[aqids_pkg::SEG_SENSITIVE]) begin
      seg = aqids_pkg::SEG_MODERATE;
    end else if (in_pm25_tenths < aqids_pkg::AQI_CLO[aqids_pkg::SEG_UNHEALTHY]) begin
      seg = aqids_pkg::SEG_SENSITIVE;
    end else if (in_pm25_tenths < aqids_pkg::AQI_CLO[aqids_pkg::SEG_VERY_UNHEALTHY]) begin
      seg = aqids_pkg::SEG_UNHEALTHY;
    end else if (in_pm25_tenths < aqids_pkg::AQI_CLO[aqids_pkg::SEG_HAZARDOUS]) begin
      seg = aqids_pkg::SEG_VERY_UNHEALTHY;
    end else begin
      seg = aqids_pkg::SEG_HAZARDOUS;
    end
  end

  assign pm_off   = in_pm25_tenths - aqids_pkg::AQI_CLO[seg];
  assign pm_x     = (pm_off > 14'(aqids_pkg::AQI_X_MAX)) ? aqids_pkg::AQI_X_MAX : pm_off[11:0];
  assign aqi_prod = 20'(pm_x) * 20'(aqids_pkg::AQI_K[seg]);

  assign t_off  = 12'(in_temperature_tenths) - aqids_pkg::THI_T_OFS;
  assign h_s    = $signed({1'b0, in_humidity_tenths});
  assign h_prod = h_s * t_off;
  assign t_gain = in_temperature_tenths * aqids_pkg::THI_T_GAIN;
  assign thi_x  = 24'(t_gain) + 24'(h_prod) + aqids_pkg::THI_BIAS;

  always_comb begin
    if (thi_x < aqids_pkg::THI_X_MIN) begin
      thi_c = aqids_pkg::THI_X_MIN;
    end else if (thi_x > aqids_pkg::THI_X_MAX) begin
      thi_c = aqids_pkg::THI_X_MAX;
    end else begin
      thi_c = thi_x;
    end
  end

  // nonnegative; sliced into thi_num divided by 8, ahead of the divide by 125
  assign thi_y = thi_c + aqids_pkg::THI_X_OFS;

  always_comb begin
    if (in_co2_ppm <= cfg.co2_good) begin
      co2_lvl = aqids_pkg::CO2_LVL_GOOD;
    end else if (in_co2_ppm <= cfg.co2_moderate) begin
      co2_lvl = aqids_pkg::CO2_LVL_MODERATE;
    end else begin
      co2_lvl = aqids_pkg::CO2_LVL_POOR;
    end
  end

  always_comb begin
    fifo_wdata.seg     = seg;
    fifo_wdata.aqi_num = aqi_prod[aqids_pkg::AQI_NUM_W-1:0];
    fifo_wdata.thi_num = thi_y[aqids_pkg::THI_NUM_W+2:3];
    fifo_wdata.co2     = in_co2_ppm;
    fifo_wdata.co2_lvl = co2_lvl;
  end

endmodule

>>> design/aqids_fifo.sv
// Two-entry queue between the front end and the back end.
module aqids_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  aqids_pkg::item_t wdata,
  output logic             full,
  input  logic             pop,
  output aqids_pkg::item_t rdata,
  output logic             empty
);

  localparam int PTR_W = (aqids_pkg::FIFO_DEPTH > 1) ? $clog2(aqids_pkg::FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(aqids_pkg::FIFO_DEPTH + 1);

  aqids_pkg::item_t mem_r [aqids_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [PTR_W-1:0] wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_nxt;
  logic [CNT_W-1:0] count_nxt;

  assign full  = (count_r == CNT_W'(aqids_pkg::FIFO_DEPTH));
  assign empty = (count_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(aqids_pkg::FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(aqids_pkg::FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

>>> design/aqids_back.sv
// Back end: divides, saturates, accumulates the day and forms averages and recommendations.
module aqids_back #(
  parameter int PERIODS_PER_DAY = 6
) (
  input  logic               clk,
  input  logic               rst_n,
  input  aqids_pkg::cfg_t    cfg,
  input  logic               fifo_empty,
  input  aqids_pkg::item_t   fifo_rdata,
  output logic               fifo_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output aqids_pkg::result_t out_res
);

  localparam int CNT_W   = $clog2(PERIODS_PER_DAY + 1);
  localparam int AVG_SH  = $clog2(PERIODS_PER_DAY);
  localparam int AVG_A_S = 12 + AVG_SH;
  localparam int AVG_C_S = 16 + AVG_SH;
  localparam int AVG_T_S = 18 + AVG_SH;
  localparam logic [12:0] AVG_A_M =
    13'(((64'd1 << AVG_A_S) + PERIODS_PER_DAY - 1) / PERIODS_PER_DAY);
  localparam logic [16:0] AVG_C_M =
    17'(((64'd1 << AVG_C_S) + PERIODS_PER_DAY - 1) / PERIODS_PER_DAY);
  localparam logic [18:0] AVG_T_M =
    19'(((64'd1 << AVG_T_S) + PERIODS_PER_DAY - 1) / PERIODS_PER_DAY);
  // offset that keeps the THI sum nonnegative and divides out exactly
  localparam logic [18:0] AVG_T_OFS  = 19'(PERIODS_PER_DAY * 16384);
  localparam logic [17:0] AVG_T_BIAS = 18'd16384;

  localparam logic [11:0]        AQI_SUM_MAX = 12'hFFF;
  localparam logic [15:0]        CO2_SUM_MAX = 16'hFFFF;
  localparam logic signed [15:0] THI_SUM_MAX = 16'sd16383;
  localparam logic signed [15:0] THI_SUM_MIN = -16'sd16384;
  localparam logic [13:0]        CO2_AVG_MAX = 14'h3FFF;

  function automatic logic [1:0] thi_category(input logic signed [11:0] v);
    logic [1:0] lvl;
    if (v < aqids_pkg::THI_LIM_1) lvl = aqids_pkg::THI_LVL_0;
    else if (v < aqids_pkg::THI_LIM_2) lvl = aqids_pkg::THI_LVL_1;
    else if (v < aqids_pkg::THI_LIM_3) lvl = aqids_pkg::THI_LVL_2;
    else lvl = aqids_pkg::THI_LVL_3;
    return lvl;
  endfunction

  function automatic logic [2:0] rec_thi_category(input logic signed [11:0] v);
    logic [2:0] lvl;
    if (v < aqids_pkg::THI_LIM_1) lvl = aqids_pkg::REC_THI_LVL_0;
    else if (v < aqids_pkg::THI_LIM_2) lvl = aqids_pkg::REC_THI_LVL_1;
    else if (v < aqids_pkg::THI_LIM_3) lvl = aqids_pkg::REC_THI_LVL_2;
    else if (v < aqids_pkg::THI_LIM_4) lvl = aqids_pkg::REC_THI_LVL_3;
    else lvl = aqids_pkg::REC_THI_LVL_4;
    return lvl;
  endfunction

  logic adv;

  // stage 1: reciprocal multiplies
  logic [38:0]         aqi_prod;
  logic [38:0]         thi_prod;
  logic                s1_valid_r;
  aqids_pkg::aqi_seg_t s1_seg_r;
  logic [8:0]          s1_aqi_q_r;
  logic [11:0]         s1_thi_q_r;
  logic [13:0]         s1_co2_r;
  logic [1:0]          s1_co2_lvl_r;

  // stage 2: results and accumulation
  logic [9:0]          aqi_raw;
  logic [8:0]          aqi_v;
  logic signed [11:0]  thi_v;
  logic [12:0]         aqi_add;
  logic [16:0]         co2_add;
  logic signed [15:0]  thi_add;
  logic [11:0]         aqi_sum_nxt;
  logic [15:0]         co2_sum_nxt;
  logic signed [14:0]  thi_sum_nxt;
  logic [CNT_W-1:0]    cnt_inc;
  logic                day_end;
  logic [CNT_W-1:0]    cnt_r;
  logic [11:0]         aqi_sum_r;
  logic [15:0]         co2_sum_r;
  logic signed [14:0]  thi_sum_r;
  logic                s2_valid_r;
  logic [8:0]          s2_aqi_r;
  logic [2:0]          s2_aqi_lvl_r;
  logic [1:0]          s2_co2_lvl_r;
  logic signed [11:0]  s2_thi_r;
  logic [1:0]          s2_thi_lvl_r;
  logic                s2_day_r;
  logic [11:0]         s2_aqi_tot_r;
  logic [15:0]         s2_co2_tot_r;
  logic signed [14:0]  s2_thi_tot_r;

  // stage 3: average multiplies
  logic [24:0]         avg_a_prod;
  logic [32:0]         avg_c_prod;
  logic [18:0]         thi_u;
  logic [36:0]         avg_t_prod;
  logic [17:0]         avg_t_uq;
  logic                s3_valid_r;
  logic [8:0]          s3_aqi_r;
  logic [2:0]          s3_aqi_lvl_r;
  logic [1:0]          s3_co2_lvl_r;
  logic signed [11:0]  s3_thi_r;
  logic [1:0]          s3_thi_lvl_r;
  logic                s3_day_r;
  logic [11:0]         s3_avg_a_r;
  logic [15:0]         s3_avg_c_r;
  logic signed [15:0]  s3_avg_t_r;

  // output register
  logic [8:0]          avg_a_c;
  logic [13:0]         avg_c_c;
  logic signed [11:0]  avg_t_c;
  logic [1:0]          rec_co2;
  aqids_pkg::result_t  res_nxt;
  aqids_pkg::result_t  out_res_r;
  logic                out_valid_r;

  assign adv       = !out_valid_r || out_ready;
  assign fifo_pop  = adv && !fifo_empty;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // ---- stage 1
  assign aqi_prod = 39'(fifo_rdata.aqi_num) * 39'(aqids_pkg::AQI_M[fifo_rdata.seg]);
  assign thi_prod = 39'(fifo_rdata.thi_num) * 39'(aqids_pkg::THI_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= !fifo_empty;
    end
  end

  always_ff @(posedge clk) begin
    if (fifo_pop) begin
      s1_seg_r     <= fifo_rdata.seg;
      s1_aqi_q_r   <= 9'(aqi_prod >> aqids_pkg::AQI_SH[fifo_rdata.seg]);
      s1_thi_q_r   <= 12'(thi_prod >> aqids_pkg::THI_SH);
      s1_co2_r     <= fifo_rdata.co2;
      s1_co2_lvl_r <= fifo_rdata.co2_lvl;
    end
  end

  // ---- stage 2
  assign aqi_raw = 10'(aqids_pkg::AQI_ILO[s1_seg_r]) + 10'(s1_aqi_q_r);
  assign aqi_v   = (aqi_raw > 10'(aqids_pkg::AQI_MAX)) ? aqids_pkg::AQI_MAX : aqi_raw[8:0];
  assign thi_v   = $signed(s1_thi_q_r - aqids_pkg::THI_Q_OFS);

  assign aqi_add = 13'(aqi_sum_r) + 13'(aqi_v);
  assign co2_add = 17'(co2_sum_r) + 17'(s1_co2_r);
  assign thi_add = 16'(thi_sum_r) + 16'(thi_v);

  assign aqi_sum_nxt = (aqi_add > 13'(AQI_SUM_MAX)) ? AQI_SUM_MAX : aqi_add[11:0];
  assign co2_sum_nxt = (co2_add > 17'(CO2_SUM_MAX)) ? CO2_SUM_MAX : co2_add[15:0];

  always_comb begin
    if (thi_add > THI_SUM_MAX) begin
      thi_sum_nxt = 15'(THI_SUM_MAX);
    end else if (thi_add < THI_SUM_MIN) begin
      thi_sum_nxt = 15'(THI_SUM_MIN);
    end else begin
      thi_sum_nxt = thi_add[14:0];
    end
  end

  assign cnt_inc = cnt_r + 1'b1;
  assign day_end = (cnt_inc >= CNT_W'(PERIODS_PER_DAY));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      cnt_r      <= '0;
      aqi_sum_r  <= '0;
      co2_sum_r  <= '0;
      thi_sum_r  <= '0;
    end else if (adv) begin
      s2_valid_r <= s1_valid_r;
      if (s1_valid_r) begin
        if (day_end) begin
          cnt_r     <= '0;
          aqi_sum_r <= '0;
          co2_sum_r <= '0;
          thi_sum_r <= '0;
        end else begin
          cnt_r     <= cnt_inc;
          aqi_sum_r <= aqi_sum_nxt;
          co2_sum_r <= co2_sum_nxt;
          thi_sum_r <= thi_sum_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      s2_aqi_r     <= aqi_v;
      s2_aqi_lvl_r <= aqids_pkg::aqi_category(aqi_v);
      s2_co2_lvl_r <= s1_co2_lvl_r;
      s2_thi_r     <= thi_v;
      s2_thi_lvl_r <= thi_category(thi_v);
      s2_day_r     <= day_end;
      s2_aqi_tot_r <= aqi_sum_nxt;
      s2_co2_tot_r <= co2_sum_nxt;
      s2_thi_tot_r <= thi_sum_nxt;
    end
  end

  // ---- stage 3
  assign avg_a_prod = 25'(s2_aqi_tot_r) * 25'(AVG_A_M);
  assign avg_c_prod = 33'(s2_co2_tot_r) * 33'(AVG_C_M);
  assign thi_u      = 19'(s2_thi_tot_r) + AVG_T_OFS;
  assign avg_t_prod = 37'(thi_u[17:0]) * 37'(AVG_T_M);
  assign avg_t_uq   = 18'(avg_t_prod >> AVG_T_S);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (adv) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s2_valid_r) begin
      s3_aqi_r     <= s2_aqi_r;
      s3_aqi_lvl_r <= s2_aqi_lvl_r;
      s3_co2_lvl_r <= s2_co2_lvl_r;
      s3_thi_r     <= s2_thi_r;
      s3_thi_lvl_r <= s2_thi_lvl_r;
      s3_day_r     <= s2_day_r;
      s3_avg_a_r   <= 12'(avg_a_prod >> AVG_A_S);
      s3_avg_c_r   <= 16'(avg_c_prod >> AVG_C_S);
      s3_avg_t_r   <= $signed(16'(avg_t_uq - AVG_T_BIAS));
    end
  end

  // ---- output register
  assign avg_a_c = (s3_avg_a_r > 12'(aqids_pkg::AQI_MAX)) ? aqids_pkg::AQI_MAX : s3_avg_a_r[8:0];
  assign avg_c_c = (s3_avg_c_r > 16'(CO2_AVG_MAX)) ? CO2_AVG_MAX : s3_avg_c_r[13:0];

  always_comb begin
    if (s3_avg_t_r < 16'(aqids_pkg::THI_MIN)) begin
      avg_t_c = aqids_pkg::THI_MIN;
    end else if (s3_avg_t_r > 16'(aqids_pkg::THI_MAX)) begin
      avg_t_c = aqids_pkg::THI_MAX;
    end else begin
      avg_t_c = s3_avg_t_r[11:0];
    end
  end

  always_comb begin
    if (avg_c_c <= cfg.co2_good) begin
      rec_co2 = aqids_pkg::CO2_LVL_GOOD;
    end else if (avg_c_c <= cfg.co2_moderate) begin
      rec_co2 = aqids_pkg::CO2_LVL_MODERATE;
    end else if (avg_c_c <= cfg.co2_high) begin
      rec_co2 = aqids_pkg::CO2_LVL_POOR;
    end else begin
      rec_co2 = aqids_pkg::CO2_LVL_SEVERE;
    end
  end

  always_comb begin
    res_nxt                = '0;
    res_nxt.aqi_index      = s3_aqi_r;
    res_nxt.aqi_level      = s3_aqi_lvl_r;
    res_nxt.co2_level      = s3_co2_lvl_r;
    res_nxt.thi_tenths     = s3_thi_r;
    res_nxt.thi_level      = s3_thi_lvl_r;
    res_nxt.day_done       = s3_day_r;
    if (s3_day_r) begin
      res_nxt.avg_aqi        = avg_a_c;
      res_nxt.avg_co2        = avg_c_c;
      res_nxt.avg_thi_tenths = avg_t_c;
      res_nxt.rec_aqi_level  = aqids_pkg::aqi_category(avg_a_c);
      res_nxt.rec_co2_level  = rec_co2;
      res_nxt.rec_thi_level  = rec_thi_category(avg_t_c);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid_r) begin
      out_res_r <= res_nxt;
    end
  end

endmodule

>>> design/air_quality_index_daily_summary.sv
// Top level of the PM2.5 air quality index block with daily summary. One sample
// transaction is taken per clock cycle at full rate while the queue is not full;
// each gives one result. The front end classifies the sample and forms numerators
// into a two-entry queue; the back end is a four-register pipeline (divide,
// accumulate, average, output) that advances as one whenever its output register
// is empty or being taken, so throughput follows out_ready. Every PERIODS_PER_DAY-th
// result carries the averages and recommendation levels and clears the running sums.
// CO2 limits are written through the cfg port; the user must write them only while
// the block is idle, which the block itself does not enforce.
module air_quality_index_daily_summary #(
  parameter int PERIODS_PER_DAY = 6
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [aqids_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [13:0]                         cfg_wdata,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [13:0]                         in_pm25_tenths,
  input  logic [13:0]                         in_co2_ppm,
  input  logic signed [10:0]                  in_temperature_tenths,
  input  logic [9:0]                          in_humidity_tenths,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [8:0]                          out_aqi_index,
  output logic [2:0]                          out_aqi_level,
  output logic [1:0]                          out_co2_level,
  output logic signed [11:0]                  out_thi_tenths,
  output logic [1:0]                          out_thi_level,
  output logic                                out_day_done,
  output logic [8:0]                          out_avg_aqi,
  output logic [13:0]                         out_avg_co2,
  output logic signed [11:0]                  out_avg_thi_tenths,
  output logic [2:0]                          out_rec_aqi_level,
  output logic [1:0]                          out_rec_co2_level,
  output logic [2:0]                          out_rec_thi_level
);

  aqids_pkg::cfg_t    cfg_r;
  aqids_pkg::item_t   fifo_wdata;
  aqids_pkg::item_t   fifo_rdata;
  aqids_pkg::result_t res;
  logic               fifo_push;
  logic               fifo_pop;
  logic               fifo_full;
  logic               fifo_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.co2_good     <= aqids_pkg::CO2_GOOD_RST;
      cfg_r.co2_moderate <= aqids_pkg::CO2_MODERATE_RST;
      cfg_r.co2_high     <= aqids_pkg::CO2_HIGH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        aqids_pkg::CFG_CO2_GOOD:     cfg_r.co2_good     <= cfg_wdata;
        aqids_pkg::CFG_CO2_MODERATE: cfg_r.co2_moderate <= cfg_wdata;
        aqids_pkg::CFG_CO2_HIGH:     cfg_r.co2_high     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  aqids_front u_front (
    .in_valid              (in_valid),
    .in_ready              (in_ready),
    .in_pm25_tenths        (in_pm25_tenths),
    .in_co2_ppm            (in_co2_ppm),
    .in_temperature_tenths (in_temperature_tenths),
    .in_humidity_tenths    (in_humidity_tenths),
    .cfg                   (cfg_r),
    .fifo_full             (fifo_full),
    .fifo_push             (fifo_push),
    .fifo_wdata            (fifo_wdata)
  );

  aqids_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fifo_push),
    .wdata (fifo_wdata),
    .full  (fifo_full),
    .pop   (fifo_pop),
    .rdata (fifo_rdata),
    .empty (fifo_empty)
  );

  aqids_back #(
    .PERIODS_PER_DAY (PERIODS_PER_DAY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .fifo_empty (fifo_empty),
    .fifo_rdata (fifo_rdata),
    .fifo_pop   (fifo_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (res)
  );

  assign out_aqi_index      = res.aqi_index;
  assign out_aqi_level      = res.aqi_level;
  assign out_co2_level      = res.co2_level;
  assign out_thi_tenths     = res.thi_tenths;
  assign out_thi_level      = res.thi_level;
  assign out_day_done       = res.day_done;
  assign out_avg_aqi        = res.avg_aqi;
  assign out_avg_co2        = res.avg_co2;
  assign out_avg_thi_tenths = res.avg_thi_tenths;
  assign out_rec_aqi_level  = res.rec_aqi_level;
  assign out_rec_co2_level  = res.rec_co2_level;
  assign out_rec_thi_level  = res.rec_thi_level;

`include "air_quality_index_daily_summary_assert.svh"

  `AQIDS_ASSERT_IMP(a_avg_zero_mid_day, out_valid && !out_day_done, out_avg_aqi == '0 && out_avg_co2 == '0 && out_avg_thi_tenths == '0 && out_rec_aqi_level == '0 && out_rec_co2_level == '0 && out_rec_thi_level == '0, "summary fields set on a mid-day result")
  `AQIDS_ASSERT_IMP(a_aqi_level_match, out_valid, out_aqi_level == aqids_pkg::aqi_category(out_aqi_index), "AQI level does not match AQI index")
  `AQIDS_ASSERT_IMP(a_rec_aqi_match, out_valid && out_day_done, out_rec_aqi_level == aqids_pkg::aqi_category(out_avg_aqi), "recommended AQI level does not match average AQI")
  `AQIDS_ASSERT_NXT(a_queue_holds, !fifo_empty && !fifo_pop, !fifo_empty, "queued transaction lost without a pop")

endmodule

>>> verif/air_quality_index_daily_summary_tb.sv
// Self-checking testbench for the PM2.5 AQI block with daily summary.
module air_quality_index_daily_summary_tb;

  localparam int DAY_LEN = 6;
  localparam int QUIET_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 12;
  localparam int DAYS_PER_PHASE = 42;
  localparam int PHASES = 8;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    int pm;
    int co2;
    int t;
    int h;
    bit has_aqi;
    int aqi;
    int aqi_lvl;
    bit has_thi;
    int thi;
  } sample_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [aqids_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [13:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [13:0] in_pm25_tenths = '0;
  logic [13:0] in_co2_ppm = '0;
  logic signed [10:0] in_temperature_tenths = '0;
  logic [9:0] in_humidity_tenths = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [8:0] out_aqi_index;
  logic [2:0] out_aqi_level;
  logic [1:0] out_co2_level;
  logic signed [11:0] out_thi_tenths;
  logic [1:0] out_thi_level;
  logic out_day_done;
  logic [8:0] out_avg_aqi;
  logic [13:0] out_avg_co2;
  logic signed [11:0] out_avg_thi_tenths;
  logic [2:0] out_rec_aqi_level;
  logic [1:0] out_rec_co2_level;
  logic [2:0] out_rec_thi_level;

  // predictor copy of limits and running sums
  logic [13:0] lim_good = aqids_pkg::CO2_GOOD_RST;
  logic [13:0] lim_moderate = aqids_pkg::CO2_MODERATE_RST;
  logic [13:0] lim_high = aqids_pkg::CO2_HIGH_RST;
  int day_periods = 0;
  int aqi_total = 0;
  int co2_total = 0;
  int thi_total = 0;

  aqids_pkg::result_t awaited_summaries [$];
  aqids_pkg::result_t want_out;
  int mismatches = 0;
  int results_seen = 0;
  int quiet_cycles = 0;
  int stall_left = 0;
  bit steady = 1'b0;

  int pm_edges [12] = '{0, 120, 121, 354, 355, 554, 555, 1504, 1505, 2504, 2505, 5000};

  sample_row_t directed_rows [24] = '{
    '{0,     0,     0,     0,    1'b1, 0,   aqids_pkg::AQI_LVL_GOOD,           1'b1, 464},
    '{120,   800,   250,   500,  1'b1, 50,  aqids_pkg::AQI_LVL_GOOD,           1'b0, 0},
    '{121,   801,   -243,  0,    1'b1, 51,  aqids_pkg::AQI_LVL_MODERATE,       1'b0, 0},
    '{354,   1200,  -242,  0,    1'b1, 100, aqids_pkg::AQI_LVL_MODERATE,       1'b0, 0},
    '{355,   1201,  -218,  0,    1'b1, 101, aqids_pkg::AQI_LVL_SENSITIVE,      1'b0, 0},
    '{554,   2001,  -217,  0,    1'b1, 150, aqids_pkg::AQI_LVL_SENSITIVE,      1'b0, 0},
    '{555,   2000,  -180,  3,    1'b1, 151, aqids_pkg::AQI_LVL_UNHEALTHY,      1'b0, 0},
    '{1504,  0,     -143,  0,    1'b1, 200, aqids_pkg::AQI_LVL_UNHEALTHY,      1'b0, 0},
    '{1505,  1,     -142,  0,    1'b1, 201, aqids_pkg::AQI_LVL_VERY_UNHEALTHY, 1'b0, 0},
    '{2504,  10000, 300,   1000, 1'b1, 300, aqids_pkg::AQI_LVL_VERY_UNHEALTHY, 1'b0, 0},
    '{2505,  9999,  -400,  1000, 1'b1, 301, aqids_pkg::AQI_LVL_VERY_UNHEALTHY, 1'b0, 0},
    '{5000,  5000,  850,   1000, 1'b1, 500, aqids_pkg::AQI_LVL_VERY_UNHEALTHY, 1'b1, 1850},
    '{5001,  16383, -1024, 1023, 1'b1, 500, aqids_pkg::AQI_LVL_VERY_UNHEALTHY, 1'b1, -400},
    '{10000, 16383, 1023,  1023, 1'b1, 500, aqids_pkg::AQI_LVL_VERY_UNHEALTHY, 1'b1, 1850},
    '{16383, 16383, 1023,  0,    1'b1, 500, aqids_pkg::AQI_LVL_VERY_UNHEALTHY, 1'b0, 0},
    '{8191,  16383, -1024, 0,    1'b0, 0,   aqids_pkg::AQI_LVL_GOOD,           1'b0, 0},
    '{0,     16383, 0,     0,    1'b1, 0,   aqids_pkg::AQI_LVL_GOOD,           1'b1, 464},
    '{6000,  16383, -400,  1000, 1'b1, 500, aqids_pkg::AQI_LVL_VERY_UNHEALTHY, 1'b0, 0},
    '{60,    0,     -1024, 0,    1'b0, 0,   aqids_pkg::AQI_LVL_GOOD,           1'b0, 0},
    '{240,   0,     -1024, 0,    1'b0, 0,   aqids_pkg::AQI_LVL_GOOD,           1'b0, 0},
    '{1000,  0,     -1024, 512,  1'b0, 0,   aqids_pkg::AQI_LVL_GOOD,           1'b0, 0},
    '{3000,  0,     -1024, 0,    1'b0, 0,   aqids_pkg::AQI_LVL_GOOD,           1'b0, 0},
    '{100,   0,     -600,  700,  1'b0, 0,   aqids_pkg::AQI_LVL_GOOD,           1'b0, 0},
    '{0,     0,     0,     0,    1'b1, 0,   aqids_pkg::AQI_LVL_GOOD,           1'b1, 464}
  };

  air_quality_index_daily_summary #(.PERIODS_PER_DAY(DAY_LEN)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_pm25_tenths(in_pm25_tenths), .in_co2_ppm(in_co2_ppm),
    .in_temperature_tenths(in_temperature_tenths), .in_humidity_tenths(in_humidity_tenths),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_aqi_index(out_aqi_index), .out_aqi_level(out_aqi_level),
    .out_co2_level(out_co2_level), .out_thi_tenths(out_thi_tenths),
    .out_thi_level(out_thi_level), .out_day_done(out_day_done),
    .out_avg_aqi(out_avg_aqi), .out_avg_co2(out_avg_co2),
    .out_avg_thi_tenths(out_avg_thi_tenths), .out_rec_aqi_level(out_rec_aqi_level),
    .out_rec_co2_level(out_rec_co2_level), .out_rec_thi_level(out_rec_thi_level)
  );

  always #4 clk = ~clk;

  function automatic int floor_quot(int n, int d);
    if (n >= 0) return n / d;
    return -((-n + d - 1) / d);
  endfunction

  function automatic logic [2:0] aqi_band(int a);
    if (a <= 50) return aqids_pkg::AQI_LVL_GOOD;
    if (a <= 100) return aqids_pkg::AQI_LVL_MODERATE;
    if (a <= 150) return aqids_pkg::AQI_LVL_SENSITIVE;
    if (a <= 200) return aqids_pkg::AQI_LVL_UNHEALTHY;
    return aqids_pkg::AQI_LVL_VERY_UNHEALTHY;
  endfunction

  // advances the running sums; returns the summary this sample produces
  function automatic aqids_pkg::result_t predict_summary(logic [13:0] pm, logic [13:0] co2,
                                                         logic signed [10:0] t,
                                                         logic [9:0] h);
    aqids_pkg::result_t r;
    int p, clo, chi, ilo, ihi, aqi, thi, a_avg, c_avg, t_avg;
    p = int'(pm);
    if (p <= 120) begin
      clo = 0; chi = 120; ilo = 0; ihi = 50;
    end else if (p <= 354) begin
      clo = 121; chi = 354; ilo = 51; ihi = 100;
    end else if (p <= 554) begin
      clo = 355; chi = 554; ilo = 101; ihi = 150;
    end else if (p <= 1504) begin
      clo = 555; chi = 1504; ilo = 151; ihi = 200;
    end else if (p <= 2504) begin
      clo = 1505; chi = 2504; ilo = 201; ihi = 300;
    end else begin
      clo = 2505; chi = 5000; ilo = 301; ihi = 500;
    end
    aqi = ilo + ((p - clo) * (ihi - ilo)) / (chi - clo);
    if (aqi > 500) aqi = 500;
    thi = floor_quot(800 * int'(t) + int'(h) * (int'(t) - 144) + 464000, 1000);
    if (thi < -400) thi = -400;
    if (thi > 1850) thi = 1850;

    r = '0;
    r.aqi_index = 9'(aqi);
    r.aqi_level = aqi_band(aqi);
    r.co2_level = (co2 <= lim_good) ? aqids_pkg::CO2_LVL_GOOD :
                  (co2 <= lim_moderate) ? aqids_pkg::CO2_LVL_MODERATE :
                  aqids_pkg::CO2_LVL_POOR;
    r.thi_tenths = 12'(thi);
    r.thi_level = (thi < 270) ? aqids_pkg::THI_LVL_0 : (thi < 290) ? aqids_pkg::THI_LVL_1 :
                  (thi < 320) ? aqids_pkg::THI_LVL_2 : aqids_pkg::THI_LVL_3;

    aqi_total += aqi;
    if (aqi_total > 4095) aqi_total = 4095;
    co2_total += int'(co2);
    if (co2_total > 65535) co2_total = 65535;
    thi_total += thi;
    if (thi_total > 16383) thi_total = 16383;
    if (thi_total < -16384) thi_total = -16384;

    if (day_periods + 1 >= DAY_LEN) begin
      a_avg = aqi_total / DAY_LEN;
      c_avg = co2_total / DAY_LEN;
      t_avg = floor_quot(thi_total, DAY_LEN);
      if (a_avg > 500) a_avg = 500;
      if (c_avg > 16383) c_avg = 16383;
      if (t_avg < -400) t_avg = -400;
      if (t_avg > 1850) t_avg = 1850;
      r.day_done = 1'b1;
      r.avg_aqi = 9'(a_avg);
      r.avg_co2 = 14'(c_avg);
      r.avg_thi_tenths = 12'(t_avg);
      r.rec_aqi_level = aqi_band(a_avg);
      r.rec_co2_level = (14'(c_avg) <= lim_good) ? aqids_pkg::CO2_LVL_GOOD :
                        (14'(c_avg) <= lim_moderate) ? aqids_pkg::CO2_LVL_MODERATE :
                        (14'(c_avg) <= lim_high) ? aqids_pkg::CO2_LVL_POOR :
                        aqids_pkg::CO2_LVL_SEVERE;
      r.rec_thi_level = (t_avg < 270) ? aqids_pkg::REC_THI_LVL_0 :
                        (t_avg < 290) ? aqids_pkg::REC_THI_LVL_1 :
                        (t_avg < 320) ? aqids_pkg::REC_THI_LVL_2 :
                        (t_avg < 350) ? aqids_pkg::REC_THI_LVL_3 :
                        aqids_pkg::REC_THI_LVL_4;
      day_periods = 0;
      aqi_total = 0;
      co2_total = 0;
      thi_total = 0;
    end else begin
      day_periods = day_periods + 1;
    end
    return r;
  endfunction

  // mostly short, a few long
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("result %0d: %s", results_seen, msg);
  endtask

  task automatic report_field(string field, logic signed [31:0] got_v,
                              logic signed [31:0] want_v);
    if (got_v !== want_v) begin
      report_mismatch($sformatf("%s is %0d, expected %0d", field, got_v, want_v));
    end
  endtask

  task automatic send_sample(input logic [13:0] pm, input logic [13:0] co2,
                             input logic signed [10:0] t, input logic [9:0] h,
                             output aqids_pkg::result_t want);
    int gap;
    gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pm25_tenths <= pm;
    in_co2_ppm <= co2;
    in_temperature_tenths <= t;
    in_humidity_tenths <= h;
    do @(posedge clk); while (!in_ready);
    want = predict_summary(pm, co2, t, h);
  endtask

  task automatic send_random(int mode);
    int pm, co2, t, h, k;
    aqids_pkg::result_t want;
    case (mode)
      0: begin
        pm = $urandom_range(0, 3000);
        co2 = $urandom_range(0, 3000);
        t = int'($urandom_range(0, 1250)) - 400;
        h = $urandom_range(0, 1000);
      end
      1: begin
        pm = $urandom() & 16'h3FFF;
        co2 = $urandom() & 16'h3FFF;
        t = int'($urandom_range(0, 2047)) - 1024;
        h = $urandom() & 10'h3FF;
      end
      2: begin
        pm = pm_edges[$urandom_range(0, 11)] + int'($urandom_range(0, 2)) - 1;
        if (pm < 0) pm = 0;
        k = $urandom_range(0, 2);
        co2 = (k == 0) ? int'(lim_good) : (k == 1) ? int'(lim_moderate) : int'(lim_high);
        co2 = co2 + int'($urandom_range(0, 2)) - 1;
        if (co2 < 0) co2 = 0;
        if (co2 > 16383) co2 = 16383;
        // h near zero puts THI close to its level limits
        t = int'($urandom_range(0, 120)) - 250;
        h = $urandom_range(0, 3);
      end
      3: begin
        pm = $urandom_range(0, 600);
        co2 = $urandom_range(0, 1500);
        t = int'($urandom_range(0, 824)) - 1024;
        h = $urandom_range(0, 1023);
      end
      default: begin
        pm = $urandom_range(1000, 16383);
        co2 = $urandom_range(1500, 16383);
        t = $urandom_range(250, 1023);
        h = $urandom_range(500, 1023);
      end
    endcase
    send_sample(14'(pm), 14'(co2), 11'(t), 10'(h), want);
    awaited_summaries.push_back(want);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_summaries.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // only called while the block is idle
  task automatic load_limits(input logic [13:0] good, input logic [13:0] moderate,
                             input logic [13:0] high);
    logic [1:0] idx [4];
    logic [13:0] vals [4];
    idx[0] = aqids_pkg::CFG_CO2_GOOD;
    idx[1] = CFG_UNUSED;
    idx[2] = aqids_pkg::CFG_CO2_MODERATE;
    idx[3] = aqids_pkg::CFG_CO2_HIGH;
    vals[0] = good;
    vals[1] = 14'($urandom());
    vals[2] = moderate;
    vals[3] = high;
    for (int k = 0; k < 4; k++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    lim_good = good;
    lim_moderate = moderate;
    lim_high = high;
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (stall_left == 0 && !steady && $urandom_range(0, 99) < 25) stall_left = idle_len();
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (awaited_summaries.size() == 0) begin
        report_mismatch("unexpected transaction, nothing pending");
      end else begin
        want_out = awaited_summaries.pop_front();
        report_field("aqi_index", out_aqi_index, want_out.aqi_index);
        report_field("aqi_level", out_aqi_level, want_out.aqi_level);
        report_field("co2_level", out_co2_level, want_out.co2_level);
        report_field("thi_tenths", out_thi_tenths, want_out.thi_tenths);
        report_field("thi_level", out_thi_level, want_out.thi_level);
        report_field("day_done", out_day_done, want_out.day_done);
        report_field("avg_aqi", out_avg_aqi, want_out.avg_aqi);
        report_field("avg_co2", out_avg_co2, want_out.avg_co2);
        report_field("avg_thi_tenths", out_avg_thi_tenths, want_out.avg_thi_tenths);
        report_field("rec_aqi_level", out_rec_aqi_level, want_out.rec_aqi_level);
        report_field("rec_co2_level", out_rec_co2_level, want_out.rec_co2_level);
        report_field("rec_thi_level", out_rec_thi_level, want_out.rec_thi_level);
      end
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    sample_row_t row;
    aqids_pkg::result_t want;
    logic [13:0] a, b, c, tmp;
    int r;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_sample(14'(row.pm), 14'(row.co2), 11'(row.t), 10'(row.h), want);
      if (row.has_aqi) begin
        want.aqi_index = 9'(row.aqi);
        want.aqi_level = 3'(row.aqi_lvl);
      end
      if (row.has_thi) want.thi_tenths = 12'(row.thi);
      awaited_summaries.push_back(want);
    end
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: load_limits(14'd0, 14'd0, 14'd0);
        1: load_limits(14'h3FFF, 14'h3FFF, 14'h3FFF);
        2: load_limits(14'd10000, 14'd10000, 14'd10000);
        3: load_limits(14'd3000, 14'd1000, 14'd500);
        4: load_limits(aqids_pkg::CO2_GOOD_RST, aqids_pkg::CO2_MODERATE_RST,
                       aqids_pkg::CO2_HIGH_RST);
        7: load_limits(14'($urandom()), 14'($urandom()), 14'($urandom()));
        default: begin
          a = $urandom_range(0, 10000);
          b = $urandom_range(0, 10000);
          c = $urandom_range(0, 10000);
          if (a > b) begin tmp = a; a = b; b = tmp; end
          if (b > c) begin tmp = b; b = c; c = tmp; end
          if (a > b) begin tmp = a; a = b; b = tmp; end
          load_limits(a, b, c);
        end
      endcase
      steady = (ph == 2 || ph == 5);
      repeat (DAYS_PER_PHASE) begin
        r = $urandom_range(0, 99);
        repeat (DAY_LEN) send_random((r < 40) ? 0 : (r < 60) ? 2 : (r < 75) ? 1 :
                                     (r < 85) ? 3 : 4);
      end
      settle();
    end

    if (mismatches == 0 && awaited_summaries.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
